>>> sv/ptd_pkg.sv
// Shared types, codes and constants of the periodic task dispatcher.
package ptd_pkg;

    // Default table size and the cap on due results per tick.
    localparam int NUM_TASKS_DEF = 8;
    localparam int MAX_RESULTS   = 8;
    localparam int EMIT_W        = $clog2(MAX_RESULTS + 1);

    // Field widths fixed by the item formats.
    localparam int ID_W   = 3;
    localparam int TIME_W = 32;
    localparam int PRIO_W = 16;

    // Action codes of an input item.
    localparam logic ACT_CREATE = 1'b0;
    localparam logic ACT_TICK   = 1'b1;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_CREATED = 2'd0,
        KIND_FULL    = 2'd1,
        KIND_DUE     = 2'd2,
        KIND_NONE    = 2'd3
    } t_kind;

    // Back-end sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    // Classified command as it sits in the queue.
    typedef struct packed {
        logic              is_tick;
        logic [TIME_W-1:0] now;
        logic [PRIO_W-1:0] prio;
        logic [TIME_W-1:0] period;
    } t_cmd;

    // One task entry of the sorted row.
    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] last_run;
        logic [ID_W-1:0]   id;
    } t_task;

    // Control from the sequencer to the task row.
    typedef struct packed {
        logic              insert;
        logic              rotate;
        logic              hit;
        t_task             new_task;
        logic [TIME_W-1:0] now;
    } t_cell_ctl;

endpackage

>>> sv/ptd_if.sv
// Handshake interfaces for the request and response channels.
interface ptd_req_if;
    logic                      valid;
    logic                      ready;
    logic                      action;
    logic [ptd_pkg::TIME_W-1:0] now_ms;
    logic [ptd_pkg::PRIO_W-1:0] priority_req;
    logic [ptd_pkg::TIME_W-1:0] period_ms;

    modport source (output valid, action, now_ms, priority_req, period_ms, input ready);
    modport sink   (input valid, action, now_ms, priority_req, period_ms, output ready);
endinterface

interface ptd_rsp_if;
    logic                     valid;
    logic                     ready;
    logic [1:0]               kind;
    logic [ptd_pkg::ID_W-1:0] task_id;
    logic                     last;

    modport source (output valid, kind, task_id, last, input ready);
    modport sink   (input valid, kind, task_id, last, output ready);
endinterface

>>> sv/ptd_front.sv
// Front end: accepts request items, classifies them and queues them for the back end.
module ptd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ptd_req_if.sink           i_req,
    output ptd_pkg::t_cmd     o_cmd,
    output logic              o_cmd_valid,
    input  logic              i_cmd_pop
);

    localparam int QD    = 2;
    localparam int PTR_W = $clog2(QD);
    localparam int LVL_W = $clog2(QD + 1);

    ptd_pkg::t_cmd    r_mem [QD];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [LVL_W-1:0] r_level;
    ptd_pkg::t_cmd    w_cmd_in;
    logic             w_push;

    // Classify the incoming item into a queue command.
    always_comb begin
        w_cmd_in.is_tick = (i_req.action == ptd_pkg::ACT_TICK);
        w_cmd_in.now     = i_req.now_ms;
        w_cmd_in.prio    = i_req.priority_req;
        w_cmd_in.period  = i_req.period_ms;
    end

    assign i_req.ready = (r_level != LVL_W'(QD));
    assign w_push      = i_req.valid && i_req.ready;
    assign o_cmd_valid = (r_level != '0);
    assign o_cmd       = r_mem[r_rd];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= w_cmd_in;
        end
    end

    // Queue pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + PTR_W'(1);
            end
            if (i_cmd_pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            case ({w_push, i_cmd_pop})
                2'b10:   r_level <= r_level + LVL_W'(1);
                2'b01:   r_level <= r_level - LVL_W'(1);
                default: r_level <= r_level;
            endcase
        end
    end

endmodule

>>> sv/ptd_cells.sv
// Row of task cells kept sorted by priority, then creation order; rotates during a scan.
module ptd_cells #(
    parameter int NUM_TASKS = ptd_pkg::NUM_TASKS_DEF,
    localparam int CW = $clog2(NUM_TASKS + 1)
) (
    input  logic               i_clk,
    input  ptd_pkg::t_cell_ctl i_ctl,
    input  logic [CW-1:0]      i_count,
    output ptd_pkg::t_task     o_head
);

    ptd_pkg::t_task         r_cell [NUM_TASKS];
    ptd_pkg::t_task         w_head_upd;
    logic [NUM_TASKS-1:0]   w_le;

    // Head entry as it goes to the tail, with its run time updated when due.
    always_comb begin
        w_head_upd = r_cell[0];
        if (i_ctl.hit) begin
            w_head_upd.last_run = i_ctl.now;
        end
    end

    assign o_head = r_cell[0];

    for (genvar p = 0; p < NUM_TASKS; p++) begin : g_cell
        ptd_pkg::t_task w_from_prev;
        ptd_pkg::t_task w_from_next;
        logic           w_prev_le;

        // A cell stays put on insert when it is valid and not after the new entry.
        assign w_le[p] = (CW'(p) < i_count) && (r_cell[p].prio <= i_ctl.new_task.prio);

        if (p == 0) begin : g_first
            assign w_prev_le   = 1'b1;
            assign w_from_prev = r_cell[p];
        end else begin : g_mid
            assign w_prev_le   = w_le[p-1];
            assign w_from_prev = r_cell[p-1];
        end

        if (p == NUM_TASKS - 1) begin : g_last
            assign w_from_next = r_cell[p];
        end else begin : g_inner
            assign w_from_next = r_cell[p+1];
        end

        // Insert shifts the tail right by one; rotate moves every valid entry left.
        always_ff @(posedge i_clk) begin
            if (i_ctl.insert) begin
                if (!w_le[p]) begin
                    if (w_prev_le) begin
                        r_cell[p] <= i_ctl.new_task;
                    end else begin
                        r_cell[p] <= w_from_prev;
                    end
                end
            end else if (i_ctl.rotate) begin
                if (CW'(p + 1) == i_count) begin
                    r_cell[p] <= w_head_upd;
                end else if (CW'(p) < i_count) begin
                    r_cell[p] <= w_from_next;
                end
            end
        end
    end

endmodule

>>> sv/ptd_back.sv
// Back end: executes create and tick commands and registers the results.
module ptd_back #(
    parameter int NUM_TASKS = ptd_pkg::NUM_TASKS_DEF,
    localparam int CW = $clog2(NUM_TASKS + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ptd_pkg::t_cmd      i_cmd,
    input  logic               i_cmd_valid,
    output logic               o_cmd_pop,
    ptd_rsp_if.source          o_rsp,
    output ptd_pkg::t_cell_ctl o_cell_ctl,
    output logic [CW-1:0]      o_count,
    input  ptd_pkg::t_task     i_head
);

    ptd_pkg::t_state                r_state, n_state;
    logic [CW-1:0]                  r_count, n_count;
    logic [CW-1:0]                  r_pos, n_pos;
    logic [ptd_pkg::EMIT_W-1:0]     r_emit, n_emit;
    logic                           r_hold_v, n_hold_v;
    logic [ptd_pkg::ID_W-1:0]       r_hold_id, n_hold_id;
    logic [ptd_pkg::TIME_W-1:0]     r_now, n_now;

    logic                           r_out_valid;
    ptd_pkg::t_kind                 r_out_kind;
    logic [ptd_pkg::ID_W-1:0]       r_out_id;
    logic                           r_out_last;

    logic                           w_push;
    ptd_pkg::t_kind                 w_push_kind;
    logic [ptd_pkg::ID_W-1:0]       w_push_id;
    logic                           w_push_last;
    logic                           w_space;
    logic [ptd_pkg::TIME_W-1:0]     w_diff;
    logic                           w_due;

    assign w_space = !r_out_valid || o_rsp.ready;

    // Wrap-safe elapsed test on the head of the row, limited by the result cap.
    assign w_diff = r_now - i_head.last_run;
    assign w_due  = (w_diff >= i_head.period) &&
                    (r_emit < ptd_pkg::EMIT_W'(ptd_pkg::MAX_RESULTS));

    // State register and sequencer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ptd_pkg::ST_IDLE;
            r_count  <= '0;
            r_hold_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_hold_v <= n_hold_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_emit    <= n_emit;
        r_hold_id <= n_hold_id;
        r_now     <= n_now;
    end

    // Next state, row control and result generation.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pos       = r_pos;
        n_emit      = r_emit;
        n_hold_v    = r_hold_v;
        n_hold_id   = r_hold_id;
        n_now       = r_now;
        o_cmd_pop   = 1'b0;
        o_cell_ctl  = '0;
        w_push      = 1'b0;
        w_push_kind = ptd_pkg::KIND_DUE;
        w_push_id   = '0;
        w_push_last = 1'b0;

        unique case (r_state)
            ptd_pkg::ST_IDLE: begin
                if (i_cmd_valid) begin
                    if (!i_cmd.is_tick) begin
                        if (w_space) begin
                            o_cmd_pop   = 1'b1;
                            w_push      = 1'b1;
                            w_push_last = 1'b1;
                            if (r_count == CW'(NUM_TASKS)) begin
                                w_push_kind = ptd_pkg::KIND_FULL;
                            end else begin
                                w_push_kind                  = ptd_pkg::KIND_CREATED;
                                w_push_id                    = ptd_pkg::ID_W'(r_count);
                                o_cell_ctl.insert            = 1'b1;
                                o_cell_ctl.new_task.prio     = i_cmd.prio;
                                o_cell_ctl.new_task.period   = i_cmd.period;
                                o_cell_ctl.new_task.last_run = i_cmd.now;
                                o_cell_ctl.new_task.id       = ptd_pkg::ID_W'(r_count);
                                n_count                      = r_count + CW'(1);
                            end
                        end
                    end else if (r_count == '0) begin
                        if (w_space) begin
                            o_cmd_pop   = 1'b1;
                            w_push      = 1'b1;
                            w_push_kind = ptd_pkg::KIND_NONE;
                            w_push_last = 1'b1;
                        end
                    end else begin
                        o_cmd_pop = 1'b1;
                        n_now     = i_cmd.now;
                        n_pos     = '0;
                        n_emit    = '0;
                        n_hold_v  = 1'b0;
                        n_state   = ptd_pkg::ST_SCAN;
                    end
                end
            end
            ptd_pkg::ST_SCAN: begin
                // A new due task releases the held one, which needs a free output slot.
                if (!(w_due && r_hold_v && !w_space)) begin
                    o_cell_ctl.rotate = 1'b1;
                    o_cell_ctl.hit    = w_due;
                    o_cell_ctl.now    = r_now;
                    if (w_due) begin
                        n_hold_v  = 1'b1;
                        n_hold_id = i_head.id;
                        n_emit    = r_emit + ptd_pkg::EMIT_W'(1);
                        if (r_hold_v) begin
                            w_push    = 1'b1;
                            w_push_id = r_hold_id;
                        end
                    end
                    n_pos = r_pos + CW'(1);
                    if (n_pos == r_count) begin
                        n_state = ptd_pkg::ST_FINISH;
                    end
                end
            end
            ptd_pkg::ST_FINISH: begin
                if (w_space) begin
                    w_push      = 1'b1;
                    w_push_last = 1'b1;
                    if (r_hold_v) begin
                        w_push_id = r_hold_id;
                    end else begin
                        w_push_kind = ptd_pkg::KIND_NONE;
                    end
                    n_hold_v = 1'b0;
                    n_state  = ptd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ptd_pkg::ST_IDLE;
            end
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_push) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_out_kind <= w_push_kind;
            r_out_id   <= w_push_id;
            r_out_last <= w_push_last;
        end
    end

    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.kind    = r_out_kind;
    assign o_rsp.task_id = r_out_id;
    assign o_rsp.last    = r_out_last;
    assign o_count       = r_count;

endmodule

>>> sv/periodic_task_dispatcher_core.sv
// Periodic task dispatcher: front queue, sorted task row and scan sequencer.
// An accepted item is registered in the queue; a create or an empty-table tick has its result
// registered when the sequencer takes it from the queue, and a tick passes through take, scan
// and finish before its last result. The sequencer takes no new command during a tick; its scan
// rotates the sorted task row one entry per cycle unless a due task waits for an output slot.
// Reset clears the queue, task count, sequencer and output valid; no clearing pass.
module periodic_task_dispatcher_core #(
    parameter int NUM_TASKS = ptd_pkg::NUM_TASKS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ptd_req_if.sink   i_req,
    ptd_rsp_if.source o_rsp
);

    localparam int CW = $clog2(NUM_TASKS + 1);

    ptd_pkg::t_cmd      w_cmd;
    logic               w_cmd_valid;
    logic               w_cmd_pop;
    ptd_pkg::t_cell_ctl w_cell_ctl;
    logic [CW-1:0]      w_count;
    ptd_pkg::t_task     w_head;

    ptd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_cmd       (w_cmd),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_pop   (w_cmd_pop)
    );

    ptd_cells #(
        .NUM_TASKS (NUM_TASKS)
    ) u_cells (
        .i_clk   (i_clk),
        .i_ctl   (w_cell_ctl),
        .i_count (w_count),
        .o_head  (w_head)
    );

    ptd_back #(
        .NUM_TASKS (NUM_TASKS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_pop   (w_cmd_pop),
        .o_rsp       (o_rsp),
        .o_cell_ctl  (w_cell_ctl),
        .o_count     (w_count),
        .i_head      (w_head)
    );

`ifndef SYNTH
    // The sequencer only takes a command that the queue holds.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_pop |-> w_cmd_valid)
        else $error("command popped from an empty queue");

    // The task count never passes the table size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_count <= CW'(NUM_TASKS))
        else $error("task count beyond table size");

    // Refusals and empty ticks are single results with a zero id.
    a_single_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && (o_rsp.kind == ptd_pkg::KIND_FULL || o_rsp.kind == ptd_pkg::KIND_NONE)
        |-> o_rsp.last && (o_rsp.task_id == '0))
        else $error("full or none result not final or nonzero id");

    // A create answer is always the final result of its item.
    a_create_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && (o_rsp.kind == ptd_pkg::KIND_CREATED) |-> o_rsp.last)
        else $error("created result not flagged last");
`endif

endmodule
